// File: src/utf8_latin1_case_accent_folder_defines.svh
// Assertion helpers for the folder top module.
`ifndef UTF8_LATIN1_CASE_ACCENT_FOLDER_DEFINES_SVH
`define UTF8_LATIN1_CASE_ACCENT_FOLDER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define UTF8F_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// When pre holds, post must hold in the next cycle.
`define UTF8F_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: src/utf8f_pkg.sv
package utf8f_pkg;

   localparam logic [7:0] LEAD_BYTE    = 8'hC3;
   localparam logic [7:0] CAP_LO       = 8'h80;
   localparam logic [7:0] CAP_HI       = 8'h9E;
   localparam logic [7:0] CAP_TIMES    = 8'h97;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;
   localparam logic [7:0] ASCII_CAP_LO = 8'h41;
   localparam logic [7:0] ASCII_CAP_HI = 8'h5A;

   // CSR map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_FOLD_MODE = 1'b0;

   // One result byte as it sits in the result queue
   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       last;
   } rsp_entry_type;

   // What one request turns into
   typedef struct packed {
      logic [1:0]    count;
      rsp_entry_type first;
      rsp_entry_type second;
      logic          lead_next;
   } xlate_type;

endpackage

// File: src/utf8f_xlate.sv
module utf8f_xlate (
   input  logic [7:0]          in_byte,
   input  logic                in_end,
   input  logic                lead_pending,
   input  logic                fold_mode,
   output utf8f_pkg::xlate_type result
);
   import utf8f_pkg::*;

   // ASCII base letter of an accented vowel partner, zero when none
   function automatic logic [7:0] vowel_base(input logic [7:0] d);
      logic [7:0] e;
      logic [7:0] base;
      e    = d & 8'hDF;
      base = 8'h00;
      if (d[7:6] == 2'b10) begin
         if (e <= 8'h83) base = 8'h61;
         else if (e >= 8'h88 && e <= 8'h8B) base = 8'h65;
         else if (e >= 8'h8C && e <= 8'h8F) base = 8'h69;
         else if (e >= 8'h92 && e <= 8'h96) base = 8'h6F;
         else if (e >= 8'h99 && e <= 8'h9C) base = 8'h75;
      end
      return base;
   endfunction

   logic [7:0] base;
   logic [7:0] partner;
   logic [7:0] single;

   assign base = vowel_base(in_byte);

   // Latin-1 capital partner gets lowercased outside fold mode
   always_comb begin
      partner = in_byte;
      if (!fold_mode && in_byte >= CAP_LO && in_byte <= CAP_HI && in_byte != CAP_TIMES) begin
         partner = in_byte + CASE_OFFSET;
      end
   end

   // ASCII capital lowercased
   always_comb begin
      single = in_byte;
      if (in_byte >= ASCII_CAP_LO && in_byte <= ASCII_CAP_HI) begin
         single = in_byte + CASE_OFFSET;
      end
   end

   always_comb begin
      result           = '0;
      result.lead_next = 1'b0;
      if (lead_pending) begin
         if (fold_mode && base != 8'h00) begin
            result.count = 2'd1;
            result.first = '{data: base, run_last: 1'b1, last: in_end};
         end else begin
            result.count  = 2'd2;
            result.first  = '{data: LEAD_BYTE, run_last: 1'b0, last: 1'b0};
            result.second = '{data: partner, run_last: 1'b1, last: in_end};
         end
      end else if (in_byte == LEAD_BYTE && !in_end) begin
         result.count     = 2'd0;
         result.lead_next = 1'b1;
      end else begin
         result.count = 2'd1;
         result.first = '{data: single, run_last: 1'b1, last: in_end};
      end
   end

endmodule

// File: src/utf8_latin1_case_accent_folder.sv
// UTF-8 Latin-1 case and accent folder.
// Request channel: req_valid/req_ready with req_in_byte and req_in_end, one byte of
// a UTF-8 string per request, req_in_end set on the last byte of the string.
// Response channel: rsp_valid/rsp_ready with rsp_out_byte, rsp_out_run_last and
// rsp_out_end. Each request gives zero, one or two responses; run_last marks the
// last response of a request and out_end rides on it.
// Configuration: APB write to byte address 0 sets fold_mode (bit 0); reads return it.
// Path: an accepted request goes through the input register, then the two-entry
// result queue, before its first response. Throughput: one request per cycle
// while rsp_ready stays high. A two-byte character takes two requests and gives
// at most two responses, so the result queue drains as fast as it fills.
// A request leaves the input register only when the queue has room for all of its
// responses; when the receiver stalls, the queue fills, the input register holds
// and req_ready drops.
// Reset clears the held lead byte, empties both stages and sets fold_mode to 0.
module utf8_latin1_case_accent_folder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_in_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_out_run_last,
   output logic                             rsp_out_end,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [utf8f_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import utf8f_pkg::*;
`include "utf8_latin1_case_accent_folder_defines.svh"

   logic          fold_mode_ff, fold_mode_in;
   logic          lead_ff, lead_in;
   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_byte_ff;
   logic          s1_end_ff;
   logic [1:0]    count_ff, count_in;
   rsp_entry_type ent0_ff, ent0_in;
   rsp_entry_type ent1_ff, ent1_in;
   xlate_type     xl;
   logic          pop;
   logic [1:0]    keep;
   logic [1:0]    free;
   logic          s1_fire;
   logic          csr_wr;

   // CSR port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   always_comb begin
      fold_mode_in = fold_mode_ff;
      if (csr_wr && paddr[2] == REG_FOLD_MODE) fold_mode_in = pwdata[0];
   end
   assign prdata = (paddr[2] == REG_FOLD_MODE) ? {31'b0, fold_mode_ff} : 32'b0;

   // Byte translation
   utf8f_xlate u_xlate (
      .in_byte      (s1_byte_ff),
      .in_end       (s1_end_ff),
      .lead_pending (lead_ff),
      .fold_mode    (fold_mode_ff),
      .result       (xl)
   );

   // Room check against the result queue
   assign pop     = rsp_valid && rsp_ready;
   assign keep    = count_ff - {1'b0, pop};
   assign free    = 2'd2 - keep;
   assign s1_fire = s1_valid_ff && (xl.count <= free);

   // Input register
   assign req_ready = !s1_valid_ff || s1_fire;
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) s1_valid_in = 1'b1;
      else if (s1_fire) s1_valid_in = 1'b0;
   end

   assign lead_in = s1_fire ? xl.lead_next : lead_ff;

   // Result queue, head in entry 0
   always_comb begin
      ent0_in = ent0_ff;
      ent1_in = ent1_ff;
      if (pop) ent0_in = ent1_ff;
      count_in = keep;
      if (s1_fire) begin
         count_in = keep + xl.count;
         case (keep)
            2'd0: begin
               ent0_in = xl.first;
               ent1_in = xl.second;
            end
            2'd1: begin
               ent1_in = xl.first;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = (count_ff != 2'd0);
   assign rsp_out_byte     = ent0_ff.data;
   assign rsp_out_run_last = ent0_ff.run_last;
   assign rsp_out_end      = ent0_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_mode_ff <= 1'b0;
         lead_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         count_ff     <= 2'd0;
      end else begin
         fold_mode_ff <= fold_mode_in;
         lead_ff      <= lead_in;
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_in_byte;
         s1_end_ff  <= req_in_end;
      end
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

   // Checks
   `UTF8F_ASSERT_ALWAYS(a_count_range, count_ff != 2'd3, "result queue overfilled")
   `UTF8F_ASSERT_NEXT(a_pair_fills, s1_fire && xl.count == 2'd2, count_ff == 2'd2,
      "pair did not land as two queued results")
   `UTF8F_ASSERT_ALWAYS(a_pair_whole, !rsp_valid || rsp_out_run_last || count_ff == 2'd2,
      "first half of a pair queued without its partner")
   `UTF8F_ASSERT_ALWAYS(a_end_on_last, !rsp_valid || !rsp_out_end || rsp_out_run_last,
      "string end flagged on a result that is not the last of its request")

endmodule
